// ===== design/eor_pkg.sv =====
// ============================================================================
// EXIF orientation reader package
// Shared constants, error codes and the request/response types that pass
// between the stream front end and the body parser.
// ============================================================================
package eor_pkg;

    localparam int STORE_DEPTH = 65536;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    // Error codes of a result transaction.
    localparam logic [3:0] ERR_OK     = 4'd0;
    localparam logic [3:0] ERR_MARKER = 4'd1;
    localparam logic [3:0] ERR_LENGTH = 4'd2;
    localparam logic [3:0] ERR_IDENT  = 4'd3;
    localparam logic [3:0] ERR_EARLY  = 4'd4;
    localparam logic [3:0] ERR_SHORT  = 4'd5;
    localparam logic [3:0] ERR_ORDER  = 4'd6;
    localparam logic [3:0] ERR_OFFSET = 4'd7;
    localparam logic [3:0] ERR_NOTAG  = 4'd8;
    localparam logic [3:0] ERR_VALUE  = 4'd9;

    localparam logic [15:0] ORIENT_TAG = 16'h0112;

    // Start request from the front end to the parser.
    typedef struct packed {
        logic        start;
        logic [15:0] body_length;
    } eor_req_t;

    // Completion from the parser.
    typedef struct packed {
        logic       done;
        logic [3:0] code;
        logic [3:0] value;
    } eor_rsp_t;

endpackage

// ===== design/eor_parser.sv =====
// ============================================================================
// EXIF body parser
// Walks the stored segment body one byte read at a time under a small
// sequencer: byte order, TIFF mark, IFD0 offset, tag count, entry search.
// ============================================================================
module eor_parser (
    input  logic                     clk,
    input  logic                     rst_n,
    input  eor_pkg::eor_req_t        req,
    output logic [eor_pkg::ADDR_W-1:0] rd_addr,
    input  logic [7:0]               rd_data,
    output eor_pkg::eor_rsp_t        rsp
);
    import eor_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FETCH = 4'd1;
    localparam logic [3:0] S_WAIT  = 4'd2;
    localparam logic [3:0] S_TAKE  = 4'd3;
    localparam logic [3:0] S_DONE  = 4'd4;

    // Steps of the byte walk; each step reads one body byte.
    localparam logic [3:0] K_B0   = 4'd0;
    localparam logic [3:0] K_B1   = 4'd1;
    localparam logic [3:0] K_M0   = 4'd2;
    localparam logic [3:0] K_M1   = 4'd3;
    localparam logic [3:0] K_O0   = 4'd4;
    localparam logic [3:0] K_O1   = 4'd5;
    localparam logic [3:0] K_O2   = 4'd6;
    localparam logic [3:0] K_O3   = 4'd7;
    localparam logic [3:0] K_C0   = 4'd8;
    localparam logic [3:0] K_C1   = 4'd9;
    localparam logic [3:0] K_T0   = 4'd10;
    localparam logic [3:0] K_T1   = 4'd11;
    localparam logic [3:0] K_V0   = 4'd12;
    localparam logic [3:0] K_V1   = 4'd13;

    logic [3:0]  state_reg, state_next;
    logic [3:0]  step_reg, step_next;
    logic [15:0] len_reg, len_next;
    logic        be_reg, be_next;
    logic [7:0]  first_reg, first_next;
    logic [15:0] word_reg, word_next;
    logic [16:0] cursor_reg, cursor_next;
    logic [15:0] tags_reg, tags_next;
    logic [3:0]  code_reg, code_next;
    logic [3:0]  value_reg, value_next;
    logic [16:0] addr_reg, addr_next;

    logic [15:0] word_now;
    logic [16:0] len_ext;

    assign len_ext  = {1'b0, len_reg};
    // Assemble a 16-bit word from the previous and the current byte.
    assign word_now = be_reg ? {first_reg, rd_data} : {rd_data, first_reg};
    assign rd_addr  = addr_reg[ADDR_W-1:0];

    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        len_next    = len_reg;
        be_next     = be_reg;
        first_next  = first_reg;
        word_next   = word_reg;
        cursor_next = cursor_reg;
        tags_next   = tags_reg;
        code_next   = code_reg;
        value_next  = value_reg;
        addr_next   = addr_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req.start)
                begin
                    len_next   = req.body_length;
                    value_next = 4'd0;
                    be_next    = 1'b0;
                    if (req.body_length < 16'd12)
                    begin
                        code_next  = ERR_SHORT;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        step_next  = K_B0;
                        addr_next  = 17'd0;
                        state_next = S_FETCH;
                    end
                end
            end
            S_FETCH:
                state_next = S_WAIT;
            S_WAIT:
                state_next = S_TAKE;
            S_TAKE:
            begin
                state_next = S_FETCH;
                addr_next  = addr_reg + 17'd1;
                step_next  = step_reg + 4'd1;
                first_next = rd_data;
                case (step_reg)
                    K_B0: ;
                    K_B1:
                    begin
                        if (first_reg == 8'h49 && rd_data == 8'h49)
                            be_next = 1'b0;
                        else if (first_reg == 8'h4D && rd_data == 8'h4D)
                            be_next = 1'b1;
                        else
                        begin
                            code_next  = ERR_ORDER;
                            state_next = S_DONE;
                        end
                    end
                    K_M0: ;
                    K_M1:
                    begin
                        if (word_now != 16'h002A)
                        begin
                            code_next  = ERR_ORDER;
                            state_next = S_DONE;
                        end
                    end
                    K_O0: ;
                    K_O1: word_next = word_now;
                    K_O2: ;
                    K_O3:
                    begin
                        // High half is word 4 for MM, word 6 for II.
                        if ((be_reg ? word_reg : word_now) != 16'd0)
                        begin
                            code_next  = ERR_OFFSET;
                            state_next = S_DONE;
                        end
                        else if ({1'b0, be_reg ? word_now : word_reg} > len_ext - 17'd2)
                        begin
                            code_next  = ERR_OFFSET;
                            state_next = S_DONE;
                        end
                        else
                            addr_next = {1'b0, be_reg ? word_now : word_reg};
                    end
                    K_C0: ;
                    K_C1:
                    begin
                        tags_next   = word_now;
                        cursor_next = addr_reg + 17'd1;
                        addr_next   = addr_reg + 17'd1;
                        if (word_now == 16'd0)
                        begin
                            code_next  = ERR_NOTAG;
                            state_next = S_DONE;
                        end
                        else if (addr_reg + 17'd13 > len_ext)
                        begin
                            code_next  = ERR_OFFSET;
                            state_next = S_DONE;
                        end
                    end
                    K_T0: ;
                    K_T1:
                    begin
                        if (word_now == ORIENT_TAG)
                            addr_next = cursor_reg + 17'd8;
                        else if (tags_reg == 16'd1)
                        begin
                            code_next  = ERR_NOTAG;
                            state_next = S_DONE;
                        end
                        else if (cursor_reg + 17'd24 > len_ext)
                        begin
                            code_next  = ERR_OFFSET;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            tags_next   = tags_reg - 16'd1;
                            cursor_next = cursor_reg + 17'd12;
                            addr_next   = cursor_reg + 17'd12;
                            step_next   = K_T0;
                        end
                    end
                    K_V0: ;
                    K_V1:
                    begin
                        state_next = S_DONE;
                        if ((be_reg ? first_reg : rd_data) != 8'd0 ||
                            (be_reg ? rd_data : first_reg) > 8'd8)
                            code_next = ERR_VALUE;
                        else
                        begin
                            code_next  = ERR_OK;
                            value_next = be_reg ? rd_data[3:0] : first_reg[3:0];
                        end
                    end
                    default: state_next = S_DONE;
                endcase
            end
            S_DONE:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= K_B0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg    <= len_next;
        be_reg     <= be_next;
        first_reg  <= first_next;
        word_reg   <= word_next;
        cursor_reg <= cursor_next;
        tags_reg   <= tags_next;
        code_reg   <= code_next;
        value_reg  <= value_next;
        addr_reg   <= addr_next;
    end

    assign rsp.done  = (state_reg == S_DONE);
    assign rsp.code  = code_reg;
    assign rsp.value = value_reg;

    // A start is only honored while idle.
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> state_reg == S_IDLE) else $error("start while busy");
    // Done lasts a single cycle.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |=> !rsp.done) else $error("done held");
    // A successful result carries an orientation of at most eight.
    a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.done && rsp.code == ERR_OK) |-> rsp.value <= 4'd8)
        else $error("bad value");
endmodule

// ===== design/exif_orientation_reader.sv =====
// A header error or end of stream gives its result in the cycle after the byte.
// A full body is parsed after its last byte, each byte read passing through the
// parser's fetch, wait and take states; the result is registered from its done.
// Otherwise one byte is taken per cycle; input is not ready during the walk or while
// a result waits. Reset returns to waiting for the start marker; the store is not cleared.
// ============================================================================
// EXIF orientation reader top level
// Checks the JPEG header bytes, stores the Exif body and hands it to the
// body parser; one result transaction per file.
// ============================================================================
module exif_orientation_reader (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       first_byte,
    input  logic       end_of_stream,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       success,
    output logic [3:0] orientation,
    output logic [3:0] error_code
);
    import eor_pkg::*;

    localparam logic [2:0] P_MARKER = 3'd0;
    localparam logic [2:0] P_LENGTH = 3'd1;
    localparam logic [2:0] P_IDENT  = 3'd2;
    localparam logic [2:0] P_BODY   = 3'd3;
    localparam logic [2:0] P_DONE   = 3'd4;
    localparam logic [2:0] P_WORK   = 3'd5;

    logic [2:0]  phase_reg, phase_next;
    logic [15:0] pos_reg, pos_next;
    logic [15:0] blen_reg, blen_next;
    logic [7:0]  lhigh_reg, lhigh_next;
    logic        ov_reg, ov_next;
    logic        succ_reg, succ_next;
    logic [3:0]  orient_reg, orient_next;
    logic [3:0]  code_reg, code_next;

    logic [7:0]  store [STORE_DEPTH];
    logic [7:0]  rd_data_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic        wr_en;

    eor_req_t req;
    eor_rsp_t rsp;

    logic        acc;
    logic [2:0]  ph;
    logic [7:0]  mexp;
    logic [7:0]  iexp;
    logic [15:0] len_now;
    logic [15:0] pos_cur;
    logic [15:0] pos_inc;

    assign in_ready = !ov_reg && phase_reg != P_WORK;
    assign acc      = in_valid && in_ready;
    assign len_now  = {lhigh_reg, data_byte};
    // A restarting byte counts from position zero.
    assign pos_cur  = first_byte ? 16'd0 : pos_reg;
    assign pos_inc  = pos_cur + 16'd1;

    always_comb
    begin
        case (pos_cur[1:0])
            2'd1:    mexp = 8'hD8;
            2'd3:    mexp = 8'hE1;
            default: mexp = 8'hFF;
        endcase
        case (pos_cur[2:0])
            3'd0:    iexp = 8'h45;
            3'd1:    iexp = 8'h78;
            3'd2:    iexp = 8'h69;
            3'd3:    iexp = 8'h66;
            default: iexp = 8'h00;
        endcase
    end

    // Header checks and result register.
    always_comb
    begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        blen_next   = blen_reg;
        lhigh_next  = lhigh_reg;
        ov_next     = ov_reg && !out_ready;
        succ_next   = succ_reg;
        orient_next = orient_reg;
        code_next   = code_reg;
        wr_en       = 1'b0;
        req.start   = 1'b0;
        req.body_length = blen_reg;
        ph          = first_byte ? P_MARKER : phase_reg;
        if (rsp.done)
        begin
            ov_next     = 1'b1;
            succ_next   = (rsp.code == ERR_OK);
            orient_next = rsp.value;
            code_next   = rsp.code;
            phase_next  = P_DONE;
        end
        if (acc)
        begin
            if (first_byte)
            begin
                phase_next = P_MARKER;
                pos_next   = 16'd0;
                blen_next  = 16'd0;
            end
            if (ph != P_DONE)
            begin
                succ_next   = 1'b0;
                orient_next = 4'd0;
                if (end_of_stream)
                begin
                    code_next  = ERR_EARLY;
                    ov_next    = 1'b1;
                    phase_next = P_DONE;
                end
                else
                begin
                    case (ph)
                        P_MARKER:
                        begin
                            if (data_byte != mexp &&
                                !(pos_cur[1:0] == 2'd3 && data_byte == 8'hE0))
                            begin
                                code_next = ERR_MARKER;
                                ov_next   = 1'b1;
                                phase_next = P_DONE;
                            end
                            else if (pos_cur[1:0] == 2'd3)
                            begin
                                phase_next = P_LENGTH;
                                pos_next   = 16'd0;
                            end
                            else
                                pos_next = pos_inc;
                        end
                        P_LENGTH:
                        begin
                            if (pos_reg[0] == 1'b0)
                            begin
                                lhigh_next = data_byte;
                                pos_next   = 16'd1;
                            end
                            else if (len_now < 16'd8 || len_now == 16'hFFFF)
                            begin
                                code_next = ERR_LENGTH;
                                ov_next   = 1'b1;
                                phase_next = P_DONE;
                            end
                            else
                            begin
                                blen_next  = len_now - 16'd8;
                                phase_next = P_IDENT;
                                pos_next   = 16'd0;
                            end
                        end
                        P_IDENT:
                        begin
                            if (data_byte != iexp)
                            begin
                                code_next = ERR_IDENT;
                                ov_next   = 1'b1;
                                phase_next = P_DONE;
                            end
                            else if (pos_reg[2:0] == 3'd5)
                            begin
                                pos_next = 16'd0;
                                if (blen_reg == 16'd0)
                                begin
                                    code_next = ERR_SHORT;
                                    ov_next   = 1'b1;
                                    phase_next = P_DONE;
                                end
                                else
                                    phase_next = P_BODY;
                            end
                            else
                                pos_next = pos_inc;
                        end
                        P_BODY:
                        begin
                            wr_en    = 1'b1;
                            pos_next = pos_inc;
                            if (pos_inc == blen_reg)
                            begin
                                req.start  = 1'b1;
                                phase_next = P_WORK;
                            end
                        end
                        default: ;
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= P_MARKER;
            pos_reg   <= 16'd0;
            blen_reg  <= 16'd0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            blen_reg  <= blen_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lhigh_reg  <= lhigh_next;
        succ_reg   <= succ_next;
        orient_reg <= orient_next;
        code_reg   <= code_next;
    end

    // Body store: one write port from the stream, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            store[pos_reg[ADDR_W-1:0]] <= data_byte;
        rd_data_reg <= store[rd_addr];
    end

    eor_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rd_addr (rd_addr),
        .rd_data (rd_data_reg),
        .rsp     (rsp)
    );

    assign out_valid   = ov_reg;
    assign success     = succ_reg;
    assign orientation = orient_reg;
    assign error_code  = code_reg;

    // No input is taken while the parser walks the body.
    a_work_stall: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == P_WORK |-> !in_ready) else $error("input during walk");
    // Parser completion only while in the walk phase.
    a_done_work: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.done |-> phase_reg == P_WORK) else $error("stray completion");
    // A success always reports code zero.
    a_succ_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && success |-> error_code == ERR_OK) else $error("bad success");
endmodule

// ===== sim/tb_exif_orientation_reader.sv =====
`timescale 1ns / 100ps
// ============================================================================
// Exif orientation reader testbench
// Streams JPEG headers byte by byte into the reader: directed files for each
// error path and random files with random entries, corruption, truncation
// and noise. A scoreboard predicts each file's result and checks every
// result transaction field by field, under several idling phases.
// ============================================================================
module tb_exif_orientation_reader;
    import eor_pkg::*;

    localparam int WATCHDOG_LIMIT = 40000;
    localparam int DRAIN_CYCLES   = 400;

    typedef enum logic [2:0] {PH_MARKER, PH_LENGTH, PH_IDENT, PH_BODY, PH_DONE} phase_e;
    typedef byte unsigned file_q_t[$];

    typedef struct {
        logic       success;
        logic [3:0] orientation;
        logic [3:0] code;
    } verdict_t;

    // Predicts one verdict per file from the accepted byte transactions.
    class exif_scoreboard;
        logic [7:0]  body_mem [0:65535];
        phase_e      phase;
        int unsigned pos;
        int unsigned body_len;
        int unsigned len_high;
        bit          big_end;
        bit          given;
        verdict_t    pending_q[$];
        int          errors;
        int          checked;
        int          predicted;

        function void restart();
            phase    = PH_MARKER;
            pos      = 0;
            body_len = 0;
            len_high = 0;
            big_end  = 0;
            given    = 0;
        endfunction

        function void give(logic [3:0] code, logic [3:0] val);
            verdict_t v;
            v.success     = (code == ERR_OK);
            v.orientation = (code == ERR_OK) ? val : 4'd0;
            v.code        = code;
            pending_q.push_back(v);
            predicted++;
            phase = PH_DONE;
            given = 1;
        endfunction

        function int unsigned word_at(int unsigned p);
            logic [15:0] a;
            logic [15:0] c;
            a = p[15:0];
            c = a + 16'd1;
            if (big_end)
                return {body_mem[a], body_mem[c]};
            return {body_mem[c], body_mem[a]};
        endfunction

        // Walks the stored body: byte order, TIFF mark, IFD0 and the entry search.
        function logic [3:0] parse_body(output logic [3:0] val);
            int unsigned len;
            int unsigned hi;
            int unsigned lo;
            int unsigned tags;
            int unsigned cur;
            logic [7:0]  vhi;
            logic [7:0]  vlo;
            len = body_len;
            val = 4'd0;
            if (len < 12) return ERR_SHORT;
            if (body_mem[0] == 8'h49 && body_mem[1] == 8'h49) big_end = 0;
            else if (body_mem[0] == 8'h4D && body_mem[1] == 8'h4D) big_end = 1;
            else return ERR_ORDER;
            if (word_at(2) != 32'h2A) return ERR_ORDER;
            hi = big_end ? word_at(4) : word_at(6);
            lo = big_end ? word_at(6) : word_at(4);
            if (hi != 0) return ERR_OFFSET;
            if (lo > len - 2) return ERR_OFFSET;
            tags = word_at(lo);
            if (tags == 0) return ERR_NOTAG;
            cur = lo + 2;
            forever
            begin
                if (cur > len - 12) return ERR_OFFSET;
                if (word_at(cur) == ORIENT_TAG) break;
                tags = (tags - 1) & 16'hFFFF;
                if (tags == 0) return ERR_NOTAG;
                cur += 12;
            end
            vhi = big_end ? body_mem[cur + 8] : body_mem[cur + 9];
            vlo = big_end ? body_mem[cur + 9] : body_mem[cur + 8];
            if (vhi != 0 || vlo > 8) return ERR_VALUE;
            val = vlo[3:0];
            return ERR_OK;
        endfunction

        // Notes one accepted input transaction.
        function void note(logic [7:0] b, logic fb, logic eos);
            logic [7:0]  mark [0:3];
            logic [7:0]  ident [0:5];
            int unsigned len;
            logic [3:0]  code;
            logic [3:0]  val;
            mark  = '{8'hFF, 8'hD8, 8'hFF, 8'hE1};
            ident = '{8'h45, 8'h78, 8'h69, 8'h66, 8'h00, 8'h00};
            if (fb) restart();
            if (given || phase == PH_DONE) return;
            if (eos)
            begin
                give(ERR_EARLY, 4'd0);
                return;
            end
            case (phase)
                PH_MARKER:
                begin
                    if (b != mark[pos] && !(pos == 3 && b == 8'hE0))
                        give(ERR_MARKER, 4'd0);
                    else
                    begin
                        pos++;
                        if (pos == 4)
                        begin
                            phase = PH_LENGTH;
                            pos   = 0;
                        end
                    end
                end
                PH_LENGTH:
                begin
                    if (pos == 0)
                    begin
                        len_high = b;
                        pos      = 1;
                    end
                    else
                    begin
                        len = (len_high << 8) | b;
                        if (len < 8 || len >= 16'hFFFF)
                            give(ERR_LENGTH, 4'd0);
                        else
                        begin
                            body_len = len - 8;
                            phase    = PH_IDENT;
                            pos      = 0;
                        end
                    end
                end
                PH_IDENT:
                begin
                    if (b != ident[pos])
                        give(ERR_IDENT, 4'd0);
                    else
                    begin
                        pos++;
                        if (pos == 6)
                        begin
                            pos   = 0;
                            phase = PH_BODY;
                            if (body_len == 0) give(ERR_SHORT, 4'd0);
                        end
                    end
                end
                PH_BODY:
                begin
                    body_mem[pos[15:0]] = b;
                    pos = (pos + 1) & 16'hFFFF;
                    if (pos == body_len)
                    begin
                        code = parse_body(val);
                        give(code, val);
                    end
                end
                default: ;
            endcase
        endfunction

        // Compares one result transaction with the oldest prediction.
        function void check(logic s, logic [3:0] o, logic [3:0] c);
            verdict_t v;
            if (pending_q.size() == 0)
            begin
                $display("%0t: unexpected result success=%0d orientation=%0d code=%0d",
                         $time, s, o, c);
                errors++;
                return;
            end
            v = pending_q.pop_front();
            checked++;
            if (s !== v.success)
            begin
                $display("%0t: success expected %0d actual %0d", $time, v.success, s);
                errors++;
            end
            if (o !== v.orientation)
            begin
                $display("%0t: orientation expected %0d actual %0d", $time, v.orientation, o);
                errors++;
            end
            if (c !== v.code)
            begin
                $display("%0t: error_code expected %0d actual %0d", $time, v.code, c);
                errors++;
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] data_byte;
    logic       first_byte;
    logic       end_of_stream;
    logic       out_valid;
    logic       out_ready;
    logic       success;
    logic [3:0] orientation;
    logic [3:0] error_code;

    exif_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    int items_sent;
    int files_sent;
    int quiet_cycles;

    exif_orientation_reader u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .first_byte    (first_byte),
        .end_of_stream (end_of_stream),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .success       (success),
        .orientation   (orientation),
        .error_code    (error_code)
    );

    initial
    begin
        clk = 0;
    end

    always #2 clk = ~clk;

    // Result side: check accepted results and stall at random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
                sb.check(success, orientation, error_code);
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog on cycles with no transaction on either side.
    always @(posedge clk)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // Drives one byte transaction and waits for its acceptance.
    task automatic send_item(logic [7:0] b, logic fb, logic eos);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        in_valid      <= 1'b1;
        data_byte     <= b;
        first_byte    <= fb;
        end_of_stream <= eos;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note(b, fb, eos);
        items_sent++;
    endtask

    task automatic send_file(file_q_t f, bit eos_end);
        foreach (f[i])
            send_item(f[i], i == 0, 1'b0);
        if (eos_end)
            send_item(8'($urandom_range(255)), 1'b0, 1'b1);
        files_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_q.size() != 0)
            @(posedge clk);
    endtask

    function automatic void put16(ref file_q_t f, input int p, input int v, input bit be);
        f[p]     = be ? v[15:8] : v[7:0];
        f[p + 1] = be ? v[7:0] : v[15:8];
    endfunction

    // Builds a well-formed file; the body starts at index 12, entries at body 10.
    function automatic file_q_t build_file(bit be, bit app0, int n_ent, int tag_at,
                                           int val, int val_hi, int pad);
        file_q_t f;
        int      body;
        int      e;
        body = 10 + 12 * n_ent + pad;
        f = '{8'hFF, 8'hD8, 8'hFF, app0 ? 8'hE0 : 8'hE1, 8'h00, 8'h00,
              8'h45, 8'h78, 8'h69, 8'h66, 8'h00, 8'h00};
        f[4] = 8'((body + 8) >> 8);
        f[5] = 8'((body + 8) & 8'hFF);
        for (int i = 0; i < body; i++)
            f.push_back(8'($urandom_range(255)));
        f[12] = be ? 8'h4D : 8'h49;
        f[13] = f[12];
        put16(f, 14, 16'h002A, be);
        put16(f, be ? 16 : 18, 0, be);
        put16(f, be ? 18 : 16, 8, be);
        put16(f, 20, n_ent, be);
        for (int k = 0; k < n_ent; k++)
        begin
            e = 22 + 12 * k;
            if (k == tag_at)
            begin
                put16(f, e, ORIENT_TAG, be);
                f[e + (be ? 8 : 9)] = 8'(val_hi);
                f[e + (be ? 9 : 8)] = 8'(val);
            end
            else if (f[e] == 8'h01 || f[e] == 8'h12)
                f[e] = 8'h77;
        end
        return f;
    endfunction

    task automatic directed_part();
        file_q_t f;
        int      n;
        // End of stream straight after reset, then together with a restart.
        send_item(8'hA5, 1'b0, 1'b1);
        send_item(8'h5A, 1'b1, 1'b1);
        // Wrong first marker byte.
        f = build_file(0, 0, 1, 0, 1, 0, 0);
        f[0] = 8'h00;
        send_file(f, 0);
        // Valid files: APP0 little-endian value 8, big-endian value 0.
        send_file(build_file(0, 1, 2, 1, 8, 0, 2), 1);
        send_file(build_file(1, 0, 3, 0, 0, 0, 0), 0);
        // Segment length too small and the reserved maximum.
        f = build_file(0, 0, 1, 0, 3, 0, 0);
        f[4] = 8'd0;
        f[5] = 8'd7;
        send_file(f, 0);
        f = build_file(1, 0, 1, 0, 3, 0, 0);
        f[4] = 8'hFF;
        f[5] = 8'hFF;
        send_file(f, 0);
        // Empty body, then a body one byte short of the minimum.
        f = build_file(0, 0, 1, 0, 3, 0, 0);
        f = f[0:11];
        f[4] = 8'd0;
        f[5] = 8'd8;
        send_file(f, 1);
        f = build_file(0, 0, 1, 0, 3, 0, 0);
        f = f[0:22];
        f[5] = 8'd19;
        send_file(f, 0);
        // Identifier mismatch, byte order mismatch, bad TIFF mark.
        f = build_file(0, 0, 1, 0, 3, 0, 0);
        f[8] = 8'h78 ^ 8'h20;
        send_file(f, 0);
        f = build_file(0, 0, 1, 0, 3, 0, 0);
        f[13] = 8'h4D;
        send_file(f, 0);
        f = build_file(1, 0, 1, 0, 3, 0, 0);
        f[15] = 8'h2B;
        send_file(f, 0);
        // Offset upper half nonzero, offset past the body.
        f = build_file(0, 0, 1, 0, 3, 0, 0);
        f[19] = 8'h01;
        send_file(f, 0);
        f = build_file(1, 0, 1, 0, 3, 0, 0);
        n = f.size() - 12;
        put16(f, 18, n - 1, 1);
        send_file(f, 0);
        // Tag count zero, tag missing, entries running past the body.
        f = build_file(0, 0, 2, 0, 3, 0, 0);
        put16(f, 20, 0, 0);
        send_file(f, 0);
        send_file(build_file(1, 0, 3, -1, 3, 0, 4), 0);
        f = build_file(0, 0, 2, -1, 3, 0, 0);
        put16(f, 20, 16'hFFFF, 0);
        send_file(f, 0);
        // Value above 8 and nonzero upper value byte.
        send_file(build_file(0, 0, 1, 0, 9, 0, 0), 0);
        send_file(build_file(1, 0, 2, 1, 5, 1, 0), 0);
        // End of stream inside the body, bytes after a result, and a long body.
        f = build_file(0, 0, 2, 1, 6, 0, 0);
        f = f[0:20];
        send_file(f, 1);
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        send_file(build_file(1, 0, 1, 0, 7, 0, 200), 0);
        wait_drained();
    endtask

    task automatic random_part();
        file_q_t f;
        int      k;
        int      mode;
        int      nf;
        int      base;
        int      span;
        nf   = 0;
        base = items_sent;
        span = (base + 400 < 1500) ? (1500 - base) / 4 : 100;
        while (items_sent < 1500)
        begin
            mode = ((items_sent - base) / span) % 4;
            send_idle_pct  = (mode == 1) ? 49 : (mode == 3) ? 11 : 0;
            recv_stall_pct = (mode == 2) ? 49 : (mode == 3) ? 11 : 0;
            nf++;
            if ($urandom_range(9) == 0)
            begin
                // Noise bytes with random flags.
                repeat ($urandom_range(1, 8))
                    send_item(8'($urandom_range(255)), $urandom_range(3) == 0,
                              $urandom_range(7) == 0);
            end
            else
            begin
                k = $urandom_range(1, 6);
                f = build_file($urandom_range(1), $urandom_range(1), k,
                               ($urandom_range(7) == 0) ? -1 : $urandom_range(k - 1),
                               ($urandom_range(5) == 0) ? $urandom_range(255)
                                                        : $urandom_range(8),
                               ($urandom_range(9) == 0) ? $urandom_range(255) : 0,
                               $urandom_range(6));
                if ($urandom_range(4) == 0)
                    f[$urandom_range(f.size() - 1)] = 8'($urandom_range(255));
                if ($urandom_range(9) == 0)
                    put16(f, 20, $urandom_range(16'hFFFF), f[12] == 8'h4D);
                if ($urandom_range(9) == 0)
                    f = f[0:$urandom_range(f.size() - 1)];
                send_file(f, $urandom_range(3) == 0);
            end
            if (nf == 3 || $urandom_range(39) == 0)
                wait_drained();
        end
    endtask

    initial
    begin
        sb = new;
        sb.restart();
        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        data_byte      <= 8'h00;
        first_byte     <= 1'b0;
        end_of_stream  <= 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        items_sent     = 0;
        files_sent     = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed_part();
        random_part();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.pending_q.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, sb.pending_q.size());
            sb.errors++;
        end
        $display("Streamed %0d bytes in %0d files; %0d results checked, %0d mismatches.",
                 items_sent, files_sent, sb.checked, sb.errors);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== exif_orientation_reader.f =====
design/eor_pkg.sv
design/eor_parser.sv
design/exif_orientation_reader.sv
sim/tb_exif_orientation_reader.sv
